[rtl/core/srtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_pkg
// shared types and constants of the rtc register block: command codes,
// register word indices, counter geometry and reset values
// ----------------------------------------------------------------------------
package srtc_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 47;
  localparam int unsigned CountLoW = 15;
  localparam int unsigned NumRegs = 15;

  localparam logic [CmdW-1:0] CmdTick  = 2'd0;
  localparam logic [CmdW-1:0] CmdRead  = 2'd1;
  localparam logic [CmdW-1:0] CmdWrite = 2'd2;

  localparam logic [IdxW-1:0] IdxCntMsb = 4'd0;
  localparam logic [IdxW-1:0] IdxCntLsb = 4'd1;
  localparam logic [IdxW-1:0] IdxLpcr   = 4'd4;
  localparam logic [IdxW-1:0] IdxLpsr   = 4'd5;
  localparam logic [IdxW-1:0] IdxHpcr   = 4'd12;
  localparam logic [IdxW-1:0] IdxHpisr  = 4'd13;
  localparam logic [IdxW-1:0] IdxLast   = 4'd14;

  localparam logic [DataW-1:0] HpcrReset = 32'h0000_0008;

  localparam logic [1:0] LpStateSet15 = 2'd1;
  localparam logic [1:0] LpStateSet14 = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
  } srtc_req_t;

endpackage

[rtl/core/srtc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_core
// counter and register store; applies one request per enabled cycle and
// returns its read data combinationally
// ----------------------------------------------------------------------------
module srtc_core
  import srtc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  srtc_req_t        req_i,
  output logic [DataW-1:0] rdata_o
);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0]  regs_q [NumRegs];
  logic [DataW-1:0]  regs_d [NumRegs];
  logic [DataW-1:0]  lpsr_w;

  always_comb begin
    rdata_o = '0;
    if (req_i.cmd == CmdRead) begin
      if (req_i.idx == IdxCntMsb) begin
        rdata_o = cnt_q[CountW-1:CountLoW];
      end else if (req_i.idx == IdxCntLsb) begin
        rdata_o = {cnt_q[CountLoW-1:0], {(DataW-CountLoW){1'b0}}};
      end else if (req_i.idx <= IdxLast) begin
        rdata_o = regs_q[req_i.idx];
      end
    end
  end

  // low-power status after a control write
  always_comb begin
    lpsr_w = regs_q[IdxLpsr];
    if (req_i.data[15]) begin
      lpsr_w[15]    = 1'b1;
      lpsr_w[13:12] = LpStateSet15;
    end
    if (req_i.data[14]) begin
      lpsr_w[14]    = 1'b1;
      lpsr_w[13:12] = LpStateSet14;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    regs_d = regs_q;
    case (req_i.cmd)
      CmdTick: begin
        cnt_d = cnt_q + 1'b1;
      end
      CmdWrite: begin
        case (req_i.idx) inside
          IdxCntMsb: begin
            cnt_d = {req_i.data, cnt_q[CountLoW-1:0]};
          end
          IdxCntLsb: begin
            cnt_d = {cnt_q[CountW-1:CountLoW], req_i.data[DataW-1:DataW-CountLoW]};
          end
          IdxLpsr, IdxHpisr: begin
            regs_d[req_i.idx] = regs_q[req_i.idx] & ~req_i.data;
          end
          IdxLpcr: begin
            regs_d[IdxLpcr] = req_i.data;
            regs_d[IdxLpsr] = lpsr_w;
          end
          default: begin
            if (req_i.idx <= IdxLast) begin
              regs_d[req_i.idx] = req_i.data;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= (i == IdxHpcr) ? HpcrReset : '0;
      end
    end else if (en_i) begin
      cnt_q  <= cnt_d;
      regs_q <= regs_d;
    end
  end

endmodule

[rtl/core/secure_rtc_register_block_unit.sv]
`timescale 1ns / 1ps
// path: each accepted input is held in the input register, then its result is
// loaded into the result register and offered; the load waits while a stalled
// result is still held (input register, then result register)
// throughput: one item per cycle while the output is not stalled, limited by the single request register
// reset: asynchronous, clears the counter and registers (hp control to 0x8)
// and empties both the input and the result register
// ----------------------------------------------------------------------------
// secure_rtc_register_block_unit
// rtc register block: 47-bit tick counter seen as two words, status
// registers with write-one-to-clear and plain storage registers
// ----------------------------------------------------------------------------
module secure_rtc_register_block_unit
  import srtc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [IdxW-1:0]  reg_index_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] read_data_o
);

  logic             in_valid_q;
  srtc_req_t        req_q;
  logic             out_valid_q;
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] rdata_w;
  logic             advance;
  logic             in_xfer;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  srtc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .req_i   (req_q),
    .rdata_o (rdata_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.cmd  <= cmd_i;
      req_q.idx  <= reg_index_i;
      req_q.data <= write_data_i;
    end
    if (advance) begin
      rdata_q <= rdata_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

endmodule

[rtl/core/srtc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_checker
// port-level checks of the rtc register block, bound to the top level
// ----------------------------------------------------------------------------
module srtc_checker
  import srtc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [DataW-1:0] read_data_o
);

  a_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("transfer produced no result");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)))
    else $error("stalled result changed");

endmodule

bind secure_rtc_register_block_unit srtc_checker u_srtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);

[tb/sv/rtc_access_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_access_checker
// watches both channels of the rtc register block, keeps its own copy of the
// tick counter and register file, predicts read data for every accepted
// access and compares each returned transfer with the oldest prediction
// ----------------------------------------------------------------------------
module rtc_access_checker
  import srtc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [IdxW-1:0]  reg_index_i,
  input  logic [DataW-1:0] write_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [DataW-1:0] read_data_i,
  output int unsigned      err_count_o,
  output int unsigned      pending_o
);

  typedef struct {
    srtc_req_t        req;
    logic [DataW-1:0] read_data;
  } rtc_read_due_t;

  logic [CountW-1:0] tick_count;
  logic [DataW-1:0]  reg_file [NumRegs];
  rtc_read_due_t     read_due_q[$];

  task automatic report_mismatch(input string what, input srtc_req_t req,
                                 input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t mismatch: %s (cmd %0d idx %0d data %h) read_data %h, predicted %h",
             $time, what, req.cmd, req.idx, req.data, got, want);
    err_count_o++;
  endtask

  // applies one access to the model state and returns its read data
  function automatic logic [DataW-1:0] predict_access(input srtc_req_t req);
    logic [DataW-1:0] rd;
    rd = '0;
    case (req.cmd)
      CmdTick: begin
        tick_count = tick_count + 1'b1;
      end
      CmdRead: begin
        if (req.idx == IdxCntMsb) begin
          rd = tick_count[CountW-1:CountLoW];
        end else if (req.idx == IdxCntLsb) begin
          rd = {tick_count[CountLoW-1:0], {(DataW-CountLoW){1'b0}}};
        end else if (req.idx < NumRegs) begin
          rd = reg_file[req.idx];
        end
      end
      CmdWrite: begin
        if (req.idx == IdxCntMsb) begin
          tick_count[CountW-1:CountLoW] = req.data;
        end else if (req.idx == IdxCntLsb) begin
          tick_count[CountLoW-1:0] = req.data[DataW-1:DataW-CountLoW];
        end else if (req.idx == IdxLpsr || req.idx == IdxHpisr) begin
          reg_file[req.idx] = reg_file[req.idx] & ~req.data;
        end else if (req.idx == IdxLpcr) begin
          reg_file[IdxLpcr] = req.data;
          if (req.data[15]) begin
            reg_file[IdxLpsr][15]    = 1'b1;
            reg_file[IdxLpsr][13:12] = LpStateSet15;
          end
          // the bit 14 rule wins when both are set
          if (req.data[14]) begin
            reg_file[IdxLpsr][14]    = 1'b1;
            reg_file[IdxLpsr][13:12] = LpStateSet14;
          end
        end else if (req.idx < NumRegs) begin
          reg_file[req.idx] = req.data;
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rtc_read_due_t due;
    if (!rst_ni) begin
      tick_count = '0;
      for (int r = 0; r < NumRegs; r++) begin
        reg_file[r] = '0;
      end
      reg_file[IdxHpcr] = HpcrReset;
      read_due_q.delete();
      err_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (read_due_q.size() == 0) begin
          report_mismatch("result transfer with no access outstanding", '0,
                          read_data_i, '0);
        end else begin
          due = read_due_q.pop_front();
          if (read_data_i !== due.read_data) begin
            report_mismatch("read_data differs", due.req, read_data_i, due.read_data);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due.req       = '{cmd_i, reg_index_i, write_data_i};
        due.read_data = predict_access(due.req);
        read_due_q.push_back(due);
      end
      pending_o <= read_due_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives ticks, register reads and register writes into the rtc register
// block with random gaps and output stalls, and reports the verdict from the
// access checker that runs beside the block
// ----------------------------------------------------------------------------
module tb_top;
  import srtc_pkg::*;

  localparam int unsigned RandomItems = 750;
  localparam int unsigned BurstLen    = 50;
  localparam int unsigned MaxGap      = 19;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainCycles = 8;

  localparam logic [IdxW-1:0] HotIdx [6] = '{IdxCntMsb, IdxCntLsb, IdxLpcr,
                                             IdxLpsr, IdxHpcr, IdxHpisr};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CmdW-1:0]  cmd;
  logic [IdxW-1:0]  reg_index;
  logic [DataW-1:0] write_data;
  logic             out_valid;
  logic             out_stall;
  logic [DataW-1:0] read_data;

  int unsigned err_count;
  int unsigned pending;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  secure_rtc_register_block_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data)
  );

  rtc_access_checker access_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_i  (read_data),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  task automatic send_access(input logic [CmdW-1:0] op, input logic [IdxW-1:0] idx,
                             input logic [DataW-1:0] data);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(MaxGap, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    reg_index  <= idx;
    write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_access();
    logic [CmdW-1:0]  op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
    int unsigned      pick;
    pick = $urandom_range(99, 0);
    op   = (pick < 30) ? CmdTick : ((pick < 65) ? CmdRead : CmdWrite);
    if ($urandom_range(9, 0) < 4) begin
      idx = HotIdx[$urandom_range(5, 0)];
    end else begin
      idx = IdxW'($urandom_range(IdxLast, 0));
    end
    pick = $urandom_range(7, 0);
    data = (pick == 0) ? '0 : ((pick == 1) ? '1 : $urandom);
    send_access(op, idx, data);
  endtask

  // stop offering and wait for every outstanding read data transfer
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    cmd        <= CmdTick;
    reg_index  <= '0;
    write_data <= '0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(CmdRead,  IdxHpcr,   '0);
    send_access(CmdRead,  IdxLpsr,   '0);
    send_access(CmdWrite, IdxCntMsb, '1);
    send_access(CmdWrite, IdxCntLsb, '1);
    send_access(CmdRead,  IdxCntMsb, '0);
    send_access(CmdRead,  IdxCntLsb, '0);
    // counter wraps to zero
    send_access(CmdTick,  IdxLast,   '1);
    send_access(CmdRead,  IdxCntMsb, '0);
    send_access(CmdRead,  IdxCntLsb, '0);
    // carry from the lsb word into the msb word
    send_access(CmdWrite, IdxCntLsb, 32'hFFFE_0000);
    send_access(CmdTick,  IdxCntMsb, '0);
    send_access(CmdRead,  IdxCntMsb, '0);
    send_access(CmdWrite, IdxLpcr,   32'h0000_C000);
    send_access(CmdRead,  IdxLpsr,   '1);
    send_access(CmdRead,  IdxLpcr,   '0);
    send_access(CmdWrite, IdxLpsr,   '1);
    send_access(CmdWrite, IdxLpcr,   32'h0000_8000);
    send_access(CmdRead,  IdxLpsr,   '0);
    send_access(CmdWrite, IdxLpcr,   32'h0000_4000);
    send_access(CmdRead,  IdxLpsr,   '0);
    send_access(CmdWrite, IdxHpisr,  '1);
    send_access(CmdRead,  IdxHpisr,  '0);
    send_access(CmdWrite, IdxLast,   '1);
    send_access(CmdRead,  IdxLast,   '0);
    send_access(CmdWrite, IdxHpcr,   '0);
    send_access(CmdRead,  IdxHpcr,   '0);
    drain_results();

    for (int b = 0; b < RandomItems / BurstLen; b++) begin
      tx_idle = 1'($urandom_range(1, 0));
      rx_idle = 1'($urandom_range(1, 0));
      // long output hold-off while the input side keeps offering
      if (b == 3 || b == 10) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      if (b == 7) begin
        drain_results();
      end
      for (int n = 0; n < BurstLen; n++) begin
        send_random_access();
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("** secure_rtc_register_block_unit: PASSED **");
    end else begin
      $display("** secure_rtc_register_block_unit: FAILED **");
    end
    $finish;
  end

  // result side: one stall length per transfer, or a long hold-off on request
  initial begin
    int unsigned stall_len;
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_len = HoldCycles;
      end else begin
        stall_len = rx_idle ? $urandom_range(MaxGap, 0) : 0;
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    #1_000_000;
    $display("** secure_rtc_register_block_unit: FAILED **");
    $finish;
  end

endmodule

[secure_rtc_register_block_unit.f]
rtl/core/srtc_pkg.sv
rtl/core/srtc_core.sv
rtl/core/secure_rtc_register_block_unit.sv
rtl/core/srtc_checker.sv
tb/sv/rtc_access_checker.sv
tb/sv/tb_top.sv
